// ===== hw/rtl/ctsb_pkg.sv =====
// Package for the text console scrollback block.
// Holds port payload structs, command codes and internal control structs.
package ctsb_pkg;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] char_code;
    logic [4:0] win_row;
    logic [6:0] screen_col;
  } in_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_color;
    logic [15:0] cursor_position;
    logic [9:0]  window_top;
    logic        live_view;
  } out_t;

  typedef enum logic [2:0] {
    OP_PUT  = 3'd0,
    OP_BS   = 3'd1,
    OP_CLR  = 3'd2,
    OP_SUP  = 3'd3,
    OP_SDN  = 3'd4,
    OP_READ = 3'd5,
    OP_NOP  = 3'd6
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic init;
  } bk_stat_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_ROWCLR,
    ST_DONE
  } bk_state_e;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_BLANK,
    SEL_MEM
  } cell_sel_e;

  localparam logic [7:0]  BLANK_CHAR    = 8'h20;
  localparam logic [7:0]  NEWLINE_CHAR  = 8'h0A;
  localparam logic [7:0]  DEFAULT_COLOR = 8'h0F;
  localparam logic [15:0] PARKED_POS    = 16'hFFFF;

endpackage

// ===== hw/rtl/ctsb_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module ctsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ctsb_front.sv =====
// Front end: accepts commands, decodes the operation, queues them for the back end.
// Depends on ctsb_pkg.
module ctsb_front import ctsb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  in_t      req_i,
  input  bk_stat_t stat_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o
);

  cmd_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       dec;
  logic       push;

  always_comb begin
    dec.ch  = req_i.char_code;
    dec.row = req_i.win_row;
    dec.col = req_i.screen_col;
    case (req_i.operation)
      OP_PUT:  dec.op = OP_PUT;
      OP_BS:   dec.op = OP_BS;
      OP_CLR:  dec.op = OP_CLR;
      OP_SUP:  dec.op = OP_SUP;
      OP_SDN:  dec.op = OP_SDN;
      OP_READ: dec.op = OP_READ;
      default: dec.op = OP_NOP;
    endcase
  end

  assign busy        = (cnt_q == 2'd2) || stat_i.init;
  assign push        = start && !busy;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (stat_i.pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(stat_i.pop);
    end
  end

endmodule

// ===== hw/rtl/ctsb_back.sv =====
// Back end: executes queued console commands against the history RAM and reports status.
// Depends on ctsb_pkg; drives the port of a ctsb_ram instance.
module ctsb_back import ctsb_pkg::*; #(
  parameter int HISTORY_ROWS = 1024,
  parameter int TEXT_COLS    = 80,
  parameter int WINDOW_ROWS  = 25,
  localparam int DEPTH       = HISTORY_ROWS * TEXT_COLS,
  localparam int AW          = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i,
  input  logic          cmd_valid_i,
  input  cmd_t          cmd_i,
  output bk_stat_t      stat_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_addr_o,
  output logic [7:0]    mem_wdata_o,
  input  logic [7:0]    mem_rdata_i,
  output logic          done_o,
  output out_t          rsp_o
);

  localparam int RW = $clog2(HISTORY_ROWS);
  localparam int CW = (TEXT_COLS > 1) ? $clog2(TEXT_COLS) : 1;
  localparam int EW = RW + 8;
  localparam logic [RW-1:0] LAST_ROW = RW'(HISTORY_ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(TEXT_COLS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  bk_state_e state_q, state_d;
  logic [RW-1:0] row_q, row_d, base_q, base_d, top_q, top_d, blank_q, blank_d;
  logic [CW-1:0] col_q, col_d;
  logic          live_q, live_d;
  logic [AW-1:0] cnt_q, cnt_d;
  cell_sel_e     sel_q, sel_d;
  logic [7:0]    color_q;
  logic          shift;
  logic          pop;

  function automatic logic [RW-1:0] follow_top(input logic [RW-1:0] r);
    logic [EW-1:0] rx;
    rx = EW'(r);
    if (rx >= EW'(WINDOW_ROWS - 1)) return RW'(rx - EW'(WINDOW_ROWS - 1));
    return '0;
  endfunction

  function automatic logic [AW-1:0] phys(input logic [RW-1:0] lr, input logic [RW-1:0] b,
                                         input logic [CW-1:0] c);
    logic [RW:0] s;
    s = (RW+1)'(lr) + (RW+1)'(b);
    if (s >= (RW+1)'(HISTORY_ROWS)) s = s - (RW+1)'(HISTORY_ROWS);
    return AW'(s[RW-1:0]) * AW'(TEXT_COLS) + AW'(c);
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:   if (cnt_q == LAST_ADDR) state_d = ST_IDLE;
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == OP_CLR) state_d = ST_SWEEP;
          else if (shift) state_d = ST_ROWCLR;
          else state_d = ST_DONE;
        end
      end
      ST_SWEEP:  if (cnt_q == LAST_ADDR) state_d = ST_DONE;
      ST_ROWCLR: if (cnt_q[CW-1:0] == LAST_COL) state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    logic [RW-1:0] nr, lt;
    logic [CW-1:0] nc;
    logic [EW-1:0] hr;
    row_d = row_q; col_d = col_q; base_d = base_q; top_d = top_q;
    live_d = live_q; cnt_d = cnt_q; sel_d = sel_q; blank_d = blank_q;
    shift = 1'b0; pop = 1'b0;
    mem_we_o = 1'b0;
    mem_wdata_o = BLANK_CHAR;
    mem_addr_o = phys(row_q, base_q, col_q);
    nr = row_q; nc = col_q; lt = '0;
    hr = EW'(top_q) + EW'(cmd_i.row);
    case (state_q)
      ST_INIT, ST_SWEEP: begin
        mem_we_o = 1'b1;
        mem_addr_o = cnt_q;
        cnt_d = cnt_q + 1'b1;
      end
      ST_ROWCLR: begin
        mem_we_o = 1'b1;
        mem_addr_o = AW'(blank_q) * AW'(TEXT_COLS) + AW'(cnt_q[CW-1:0]);
        cnt_d = cnt_q + 1'b1;
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop = 1'b1;
          sel_d = SEL_ZERO;
          case (cmd_i.op)
            OP_PUT: begin
              if (cmd_i.ch != NEWLINE_CHAR) begin
                mem_we_o = 1'b1;
                mem_wdata_o = cmd_i.ch;
              end
              if (cmd_i.ch == NEWLINE_CHAR || col_q == LAST_COL) begin
                nc = '0;
                if (row_q == LAST_ROW) begin
                  shift = 1'b1;
                  base_d = (base_q == LAST_ROW) ? '0 : base_q + 1'b1;
                  blank_d = base_q;
                  cnt_d = '0;
                end else begin
                  nr = row_q + 1'b1;
                end
              end else begin
                nc = col_q + 1'b1;
              end
              row_d = nr; col_d = nc;
              live_d = 1'b1; top_d = follow_top(nr);
            end
            OP_BS: begin
              if (col_q != '0) begin
                nc = col_q - 1'b1;
              end else if (row_q != '0) begin
                nr = row_q - 1'b1;
                nc = LAST_COL;
              end
              mem_we_o = 1'b1;
              mem_addr_o = phys(nr, base_q, nc);
              row_d = nr; col_d = nc;
              live_d = 1'b1; top_d = follow_top(nr);
            end
            OP_CLR: begin
              row_d = '0; col_d = '0; top_d = '0; base_d = '0;
              live_d = 1'b1; cnt_d = '0;
            end
            OP_SUP: begin
              if (top_q != '0) begin
                top_d = top_q - 1'b1;
                live_d = 1'b0;
              end
            end
            OP_SDN: begin
              lt = follow_top(row_q);
              if (top_q < lt) begin
                top_d = top_q + 1'b1;
                if (top_d == lt) live_d = 1'b1;
              end
            end
            OP_READ: begin
              mem_addr_o = phys(hr[RW-1:0], base_q, CW'(cmd_i.col));
              if (EW'(cmd_i.row) < EW'(WINDOW_ROWS) && 8'(cmd_i.col) < 8'(TEXT_COLS)
                  && hr < EW'(HISTORY_ROWS)) begin
                sel_d = SEL_MEM;
              end else begin
                sel_d = SEL_BLANK;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    logic [RW-1:0] sr;
    sr = row_q - top_q;
    done_o = (state_q == ST_DONE);
    rsp_o.cell_color = color_q;
    rsp_o.window_top = 10'(32'(top_q));
    rsp_o.live_view  = live_q;
    case (sel_q)
      SEL_MEM:   rsp_o.cell_char = mem_rdata_i;
      SEL_BLANK: rsp_o.cell_char = BLANK_CHAR;
      default:   rsp_o.cell_char = 8'h00;
    endcase
    if (live_q && row_q >= top_q && EW'(sr) < EW'(WINDOW_ROWS)) begin
      rsp_o.cursor_position = 16'(32'(sr) * TEXT_COLS + 32'(col_q));
    end else begin
      rsp_o.cursor_position = PARKED_POS;
    end
  end

  assign stat_o.pop  = pop;
  assign stat_o.init = (state_q == ST_INIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      row_q   <= '0;
      col_q   <= '0;
      base_q  <= '0;
      top_q   <= '0;
      live_q  <= 1'b1;
      cnt_q   <= '0;
      sel_q   <= SEL_ZERO;
      blank_q <= '0;
      color_q <= DEFAULT_COLOR;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      base_q  <= base_d;
      top_q   <= top_d;
      live_q  <= live_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      blank_q <= blank_d;
      if (cfg_we_i) color_q <= cfg_wdata_i;
    end
  end

endmodule

// ===== hw/rtl/text_console_scrollback.sv =====
// Top level of the text console with scrollback history.
// Depends on ctsb_pkg, ctsb_front, ctsb_back and ctsb_ram.
//
// Commands enter on req_i and are taken at a clock edge with start high and
// busy low. The front end queues up to two commands; the back end runs them
// one at a time against a single-port history RAM of HISTORY_ROWS*TEXT_COLS
// bytes kept as a ring of rows, and puts each result on rsp_o for exactly
// one cycle with done_o high. The receiver cannot stall; results come out
// in command order.
// Put char, backspace, scroll, read cell and no-op pass through execute, then
// report in the back end (the read uses the registered RAM output); the front
// end takes a new command while the back end is still on the last one, unless
// its queue is full. A put char that runs past the last history row rotates
// the ring and blanks one row before it reports. Clear walks the whole RAM.
// After reset the RAM is filled with spaces while busy stays high.
// text_color is written through cfg_we_i and cfg_wdata_i and resets to 0x0F.
module text_console_scrollback import ctsb_pkg::*; #(
  parameter int HISTORY_ROWS = 1024,
  parameter int TEXT_COLS    = 80,
  parameter int WINDOW_ROWS  = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  in_t        req_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output logic       done_o,
  output out_t       rsp_o
);

  localparam int DEPTH = HISTORY_ROWS * TEXT_COLS;
  localparam int AW    = $clog2(DEPTH);

  bk_stat_t      stat;
  logic          cmd_valid;
  cmd_t          cmd;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;

  ctsb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .stat_i     (stat),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd)
  );

  ctsb_back #(
    .HISTORY_ROWS(HISTORY_ROWS),
    .TEXT_COLS   (TEXT_COLS),
    .WINDOW_ROWS (WINDOW_ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .mem_we_o   (mem_we),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

  ctsb_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

endmodule

// ===== hw/rtl/ctsb_checker.sv =====
// Port-level checks for text_console_scrollback, attached by bind.
// Depends on ctsb_pkg.
module ctsb_checker import ctsb_pkg::*; #(
  parameter int TEXT_COLS   = 80,
  parameter int WINDOW_ROWS = 25
) (
  input logic clk_i,
  input logic rst_ni,
  input logic busy,
  input logic done_o,
  input out_t rsp_o
);

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held two cycles");

  a_parked_when_scrolled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.live_view) |-> (rsp_o.cursor_position == PARKED_POS))
    else $error("cursor shown while scrolled back");

  a_cursor_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.cursor_position != PARKED_POS) |->
      (32'(rsp_o.cursor_position) < WINDOW_ROWS * TEXT_COLS))
    else $error("cursor position outside window");

  a_init_busy: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> busy) else $error("accepting during reset fill");

endmodule

bind text_console_scrollback ctsb_checker #(
  .TEXT_COLS  (TEXT_COLS),
  .WINDOW_ROWS(WINDOW_ROWS)
) u_ctsb_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);

// ===== test/ctsb_checker.sv =====
// Checker for the text console scrollback block: watches command and result
// transfers, predicts each result and compares it. Depends on ctsb_pkg.
module ctsb_scoreboard import ctsb_pkg::*; #(
  parameter int HISTORY_ROWS = 1024,
  parameter int TEXT_COLS    = 80,
  parameter int WINDOW_ROWS  = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       busy,
  input  in_t        req_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       done_o,
  input  out_t       rsp_o,
  output int         mismatch_cnt,
  output int         pending_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] hist [HISTORY_ROWS][TEXT_COLS];
  int         ring_base;
  int         cur_row;
  int         cur_col;
  int         win_top;
  bit         live;
  logic [7:0] text_color;
  out_t       predicted_q[$];

  function automatic int hrow(int r);
    return (ring_base + r) % HISTORY_ROWS;
  endfunction

  function automatic int follow_top();
    return (cur_row >= WINDOW_ROWS - 1) ? cur_row - (WINDOW_ROWS - 1) : 0;
  endfunction

  task automatic blank_history();
    for (int r = 0; r < HISTORY_ROWS; r++)
      for (int c = 0; c < TEXT_COLS; c++) hist[r][c] = BLANK_CHAR;
    ring_base = 0;
    cur_row = 0;
    cur_col = 0;
    win_top = 0;
    live = 1'b1;
  endtask

  task automatic line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row >= HISTORY_ROWS) begin
      ring_base = (ring_base + 1) % HISTORY_ROWS;
      for (int c = 0; c < TEXT_COLS; c++) hist[hrow(HISTORY_ROWS - 1)][c] = BLANK_CHAR;
      cur_row = HISTORY_ROWS - 1;
    end
  endtask

  function automatic logic [15:0] cursor_pos();
    int sr;
    if (!live || cur_row < win_top) return PARKED_POS;
    sr = cur_row - win_top;
    if (sr >= WINDOW_ROWS) return PARKED_POS;
    return 16'(sr * TEXT_COLS + cur_col);
  endfunction

  task automatic console_step(input in_t t, output out_t r);
    logic [7:0] cell_val;
    int         lt;
    cell_val = 8'h00;
    case (t.operation)
      OP_PUT: begin
        if (t.char_code == NEWLINE_CHAR) begin
          line_feed();
        end else begin
          hist[hrow(cur_row)][cur_col] = t.char_code;
          cur_col++;
          if (cur_col >= TEXT_COLS) line_feed();
        end
        live = 1'b1;
        win_top = follow_top();
      end
      OP_BS: begin
        if (cur_col > 0) begin
          cur_col--;
        end else if (cur_row > 0) begin
          cur_row--;
          cur_col = TEXT_COLS - 1;
        end
        hist[hrow(cur_row)][cur_col] = BLANK_CHAR;
        live = 1'b1;
        win_top = follow_top();
      end
      OP_CLR: blank_history();
      OP_SUP: begin
        if (win_top > 0) begin
          win_top--;
          live = 1'b0;
        end
      end
      OP_SDN: begin
        lt = follow_top();
        if (win_top < lt) begin
          win_top++;
          if (win_top >= lt) live = 1'b1;
        end
      end
      OP_READ: begin
        if (t.win_row >= WINDOW_ROWS || t.screen_col >= TEXT_COLS ||
            win_top + t.win_row >= HISTORY_ROWS) cell_val = BLANK_CHAR;
        else cell_val = hist[hrow(win_top + t.win_row)][t.screen_col];
      end
      default: ;
    endcase
    r.cell_char       = cell_val;
    r.cell_color      = text_color;
    r.cursor_position = cursor_pos();
    r.window_top      = 10'(win_top);
    r.live_view       = live;
  endtask

  initial begin
    blank_history();
    text_color = DEFAULT_COLOR;
    mismatch_cnt = 0;
    pending_cnt = 0;
  end

  always @(posedge clk_i) begin
    out_t want;
    out_t pred;
    if (rst_ni) begin
      if (cfg_we_i) text_color = cfg_wdata_i;
      if (done_o) begin
        if (predicted_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("%t: unexpected result %h", $realtime, rsp_o);
        end else begin
          want = predicted_q.pop_front();
          if (rsp_o !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%t: mismatch char %h/%h color %h/%h cursor %h/%h top %0d/%0d live %b/%b",
                       $realtime, want.cell_char, rsp_o.cell_char, want.cell_color,
                       rsp_o.cell_color, want.cursor_position, rsp_o.cursor_position,
                       want.window_top, rsp_o.window_top, want.live_view, rsp_o.live_view);
          end
        end
      end
      if (start && !busy) begin
        console_step(req_i, pred);
        predicted_q.push_back(pred);
      end
      pending_cnt = predicted_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for text_console_scrollback: drives commands and config,
// runs directed and random phases; ctsb_scoreboard does the prediction.
module tb_top;
  import ctsb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HISTORY_ROWS = 1024;
  localparam int TEXT_COLS    = 80;
  localparam int WINDOW_ROWS  = 25;
  localparam logic [2:0] OP_SPARE = 3'd7;
  localparam int STALL_LIMIT = 500000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_t        req_i = '0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       done_o;
  out_t       rsp_o;
  int         mismatch_cnt;
  int         pending_cnt;
  int         idle_cycles = 0;
  int         gap_pct = 0;

  always #4 clk_i = ~clk_i;

  text_console_scrollback #(
    .HISTORY_ROWS(HISTORY_ROWS), .TEXT_COLS(TEXT_COLS), .WINDOW_ROWS(WINDOW_ROWS)
  ) dut (.*);

  ctsb_scoreboard #(
    .HISTORY_ROWS(HISTORY_ROWS), .TEXT_COLS(TEXT_COLS), .WINDOW_ROWS(WINDOW_ROWS)
  ) u_checker (.*);

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_t mk(logic [2:0] op, logic [7:0] ch, logic [4:0] r, logic [6:0] c);
    in_t t;
    t.operation = op;
    t.char_code = ch;
    t.win_row = r;
    t.screen_col = c;
    return t;
  endfunction

  // caller is at a rising edge; returns at the edge of the transfer
  task automatic send(input in_t t);
    bit taken;
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= t;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (TEXT_COLS + 10) @(posedge clk_i);
  endtask

  task automatic set_color(input logic [7:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_t rand_item();
    in_t t;
    int  w;
    t = in_t'($urandom);
    w = $urandom_range(0, 99);
    if (w < 55) begin
      t.operation = OP_PUT;
      if ($urandom_range(0, 99) < 30) t.char_code = NEWLINE_CHAR;
    end else if (w < 65) t.operation = OP_BS;
    else if (w < 75) t.operation = OP_SUP;
    else if (w < 84) t.operation = OP_SDN;
    else if (w < 98) begin
      t.operation = OP_READ;
      if ($urandom_range(0, 3) != 0) begin
        t.win_row = 5'($urandom_range(0, WINDOW_ROWS - 1));
        t.screen_col = 7'($urandom_range(0, TEXT_COLS - 1));
      end
    end else t.operation = (w == 98) ? OP_NOP : OP_SPARE;
    return t;
  endfunction

  task automatic random_phase(input int n);
    int burst;
    send(mk(OP_CLR, 8'($urandom), 5'($urandom), 7'($urandom)));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        burst = $urandom_range(3, 30);
        for (int k = 0; k < burst; k++)
          send(mk(($urandom_range(0, 3) != 0) ? OP_SUP : OP_READ, 8'($urandom),
                  5'($urandom_range(0, WINDOW_ROWS - 1)), 7'($urandom)));
      end else begin
        send(rand_item());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send(mk(OP_BS, 8'h00, 5'd0, 7'd0));
    send(mk(OP_SUP, 8'hFF, 5'd31, 7'd127));
    send(mk(OP_SDN, 8'h00, 5'd0, 7'd0));
    send(mk(OP_PUT, 8'h00, 5'd31, 7'd127));
    send(mk(OP_PUT, 8'hFF, 5'd0, 7'd0));
    send(mk(OP_PUT, 8'h41, 5'd0, 7'd0));
    send(mk(OP_PUT, NEWLINE_CHAR, 5'd0, 7'd0));
    send(mk(OP_BS, 8'h00, 5'd0, 7'd0));
    send(mk(OP_READ, 8'h00, 5'd0, 7'd0));
    send(mk(OP_READ, 8'h00, 5'd0, 7'd1));
    send(mk(OP_READ, 8'h00, 5'd24, 7'd79));
    send(mk(OP_READ, 8'h00, 5'd25, 7'd0));
    send(mk(OP_READ, 8'hFF, 5'd31, 7'd127));
    send(mk(OP_READ, 8'h00, 5'd0, 7'd80));
    send(mk(OP_NOP, 8'h00, 5'd0, 7'd0));
    send(mk(OP_SPARE, 8'hFF, 5'd31, 7'd127));
    for (int i = 0; i < 8; i++) send(mk(OP_PUT, 8'h30 + 8'(i), 5'd0, 7'd0));
    send(mk(OP_CLR, 8'h00, 5'd0, 7'd0));
    drain();

    set_color(8'h00);
    gap_pct = 35;
    random_phase(120);
    drain();

    set_color(8'hFF);
    gap_pct = 70;
    random_phase(120);
    drain();

    set_color(8'($urandom));
    gap_pct = 0;
    random_phase(50);
    // long output run: fills the history and makes it shift
    for (int i = 0; i < HISTORY_ROWS + 40; i++)
      send(mk(OP_PUT, ($urandom_range(0, 39) != 0) ? NEWLINE_CHAR : 8'($urandom),
              5'($urandom), 7'($urandom)));
    for (int i = 0; i < 40; i++) send(mk(OP_SUP, 8'($urandom), 5'($urandom), 7'($urandom)));
    for (int i = 0; i < 150; i++) send(rand_item());
    drain();

    set_color(DEFAULT_COLOR);
    for (int i = 0; i < 30; i++) send(rand_item());
    drain();

    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
